@@ design/bhcs_pkg.sv @@
package bhcs_pkg;

  // Field widths of the stream payloads.
  localparam int HALL_W   = 3;
  localparam int DRIVE_W  = 6;
  localparam int SPEED_W  = 8;
  localparam int WINDOW_W = 16;
  localparam int SHIFT_W  = 3;
  localparam int SEQ_W    = 3;

  // Packed widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_DATA_W  = 16;

  // Register reset values.
  localparam logic [WINDOW_W-1:0] WINDOW_TICKS_RST = 16'd3906;
  localparam logic [SHIFT_W-1:0]  SPEED_SHIFT_RST  = 3'd2;

  // Speed clipping: above SPEED_CLIP the report reads SPEED_OOR.
  localparam logic [SPEED_W-1:0] SPEED_CLIP = 8'd254;
  localparam logic [SPEED_W-1:0] SPEED_OOR  = 8'd255;

  // Number of Hall codes in one electrical rotation.
  localparam logic [SEQ_W-1:0] SEQ_LEN = 3'd6;

  // Base gate patterns of the six-step table.
  localparam logic [DRIVE_W-1:0] DRIVE_PAT_A = 6'h29;
  localparam logic [DRIVE_W-1:0] DRIVE_PAT_B = 6'h26;
  localparam logic [DRIVE_W-1:0] DRIVE_PAT_C = 6'h1A;

  typedef enum logic [0:0] {
    CFG_WINDOW_TICKS = 1'b0,
    CFG_SPEED_SHIFT  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [HALL_W-1:0] hall_code;
    logic              pwm_level;
    logic              tick;
  } item_t;

  typedef struct packed {
    logic [WINDOW_W-1:0] window_ticks;
    logic [SHIFT_W-1:0]  speed_shift;
  } cfg_t;

  // Expected Hall code at each position of the rotation order 3,1,5,4,6,2.
  function automatic logic [HALL_W-1:0] hall_order_at(input logic [SEQ_W-1:0] idx);
    logic [HALL_W-1:0] code;
    case (idx)
      3'd0:    code = 3'd3;
      3'd1:    code = 3'd1;
      3'd2:    code = 3'd5;
      3'd3:    code = 3'd4;
      3'd4:    code = 3'd6;
      3'd5:    code = 3'd2;
      default: code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

@@ design/bldc_hall_commutation_speed.sv @@
// Channel  Role    Payload, lowest bit first                                  Bits
// in_      slave   tdata: hall_code[2:0], pwm_level, tick, zero pad            8
// out_     master  tdata: bridge_drive[5:0], speed[7:0], pad; tuser: speed_valid  16+1
// cfg_     write   cfg_index selects register, cfg_wdata value                16
//
// A transaction is held in the input register until the result register is
// free, and its result is then registered there. One transaction per cycle is
// accepted while the output drains.
// Reset (rst_n low, synchronous) clears valid flags, counters, Hall position
// and last drive, and reloads the configuration defaults. With out_tready low
// the input register takes one more transaction before in_tready falls.
module bldc_hall_commutation_speed #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [2:0] hall_code, [3] pwm_level, [4] tick, [7:5] zero
  input  logic [bhcs_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [5:0] bridge_drive, [13:6] speed, [15:14] zero
  output logic [bhcs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] speed_valid
  output logic                                out_tuser,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [bhcs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic                               s1_valid_r;
  logic                               s1_valid_nxt;
  bhcs_pkg::item_t                    s1_item_r;
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  logic [bhcs_pkg::OUT_TDATA_W-1:0]   out_data_r;
  logic                               out_user_r;
  bhcs_pkg::cfg_t                     cfg_r;
  logic                               in_accept;
  logic                               s1_go;
  logic [bhcs_pkg::DRIVE_W-1:0]       drive;
  logic                               speed_valid;
  logic [bhcs_pkg::SPEED_W-1:0]       speed;
  bhcs_pkg::cfg_idx_t                 cfg_sel;

  // The held item moves on when the result register is empty or drained.
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_accept = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_go ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.hall_code <= in_tdata[2:0];
      s1_item_r.pwm_level <= in_tdata[3];
      s1_item_r.tick      <= in_tdata[4];
    end
    if (s1_go) begin
      out_data_r <= {2'b00, speed, drive};
      out_user_r <= speed_valid;
    end
  end

  // Configuration registers; writes must arrive only while the block is idle (the block does not enforce this).
  assign cfg_sel = bhcs_pkg::cfg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ticks <= bhcs_pkg::WINDOW_TICKS_RST;
      cfg_r.speed_shift  <= bhcs_pkg::SPEED_SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_sel)
        bhcs_pkg::CFG_WINDOW_TICKS: cfg_r.window_ticks <= cfg_wdata;
        bhcs_pkg::CFG_SPEED_SHIFT:  cfg_r.speed_shift  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  bhcs_commutate u_commutate (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_go),
    .item  (s1_item_r),
    .drive (drive)
  );

  bhcs_speed_meter #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_speed_meter (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (s1_go),
    .item        (s1_item_r),
    .cfg         (cfg_r),
    .speed_valid (speed_valid),
    .speed       (speed)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ design/bhcs_commutate.sv @@
module bhcs_commutate (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fire,
  input  bhcs_pkg::item_t                item,
  output logic [bhcs_pkg::DRIVE_W-1:0]   drive
);

  logic [bhcs_pkg::DRIVE_W-1:0] last_drive_r;
  logic [bhcs_pkg::DRIVE_W-1:0] last_drive_nxt;
  logic [bhcs_pkg::DRIVE_W-1:0] pwm0;
  logic [bhcs_pkg::DRIVE_W-1:0] pwm2;
  logic [bhcs_pkg::DRIVE_W-1:0] pwm4;

  assign pwm0 = bhcs_pkg::DRIVE_W'(item.pwm_level);
  assign pwm2 = pwm0 << 2;
  assign pwm4 = pwm0 << 4;

  // Invalid Hall codes hold the previous pattern.
  always_comb begin
    case (item.hall_code)
      3'd1:    last_drive_nxt = bhcs_pkg::DRIVE_PAT_C | pwm0;
      3'd2:    last_drive_nxt = bhcs_pkg::DRIVE_PAT_A | pwm2;
      3'd3:    last_drive_nxt = bhcs_pkg::DRIVE_PAT_B | pwm0;
      3'd4:    last_drive_nxt = bhcs_pkg::DRIVE_PAT_B | pwm4;
      3'd5:    last_drive_nxt = bhcs_pkg::DRIVE_PAT_A | pwm4;
      3'd6:    last_drive_nxt = bhcs_pkg::DRIVE_PAT_C | pwm2;
      default: last_drive_nxt = last_drive_r;
    endcase
  end

  assign drive = last_drive_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_drive_r <= '0;
    end else if (fire) begin
      last_drive_r <= last_drive_nxt;
    end
  end

endmodule

@@ design/bhcs_speed_meter.sv @@
module bhcs_speed_meter #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fire,
  input  bhcs_pkg::item_t                item,
  input  bhcs_pkg::cfg_t                 cfg,
  output logic                           speed_valid,
  output logic [bhcs_pkg::SPEED_W-1:0]   speed
);

  localparam int CMP_W = (COUNT_WIDTH > bhcs_pkg::WINDOW_W) ? COUNT_WIDTH
                                                            : bhcs_pkg::WINDOW_W;

  logic [COUNT_WIDTH-1:0]         tick_count_r;
  logic [COUNT_WIDTH-1:0]         tick_count_nxt;
  logic [COUNT_WIDTH-1:0]         rotation_count_r;
  logic [COUNT_WIDTH-1:0]         rotation_count_nxt;
  logic [bhcs_pkg::SEQ_W-1:0]     seq_index_r;
  logic [bhcs_pkg::SEQ_W-1:0]     seq_index_nxt;
  logic [COUNT_WIDTH-1:0]         tick_inc;
  logic [CMP_W-1:0]               limit;
  logic [COUNT_WIDTH-1:0]         rot_shifted;
  logic                           window_done;
  logic                           in_order;

  // Saturating tick count including this item's tick.
  assign tick_inc = (item.tick && (tick_count_r != '1)) ? tick_count_r + 1'b1
                                                        : tick_count_r;

  assign window_done = CMP_W'(tick_inc) >= CMP_W'(cfg.window_ticks);
  assign limit       = CMP_W'(bhcs_pkg::SPEED_CLIP) << cfg.speed_shift;
  assign rot_shifted = rotation_count_r >> cfg.speed_shift;

  // The position is checked before the order table is consulted.
  assign in_order = (seq_index_r < bhcs_pkg::SEQ_LEN) &&
                    (item.hall_code == bhcs_pkg::hall_order_at(seq_index_r));

  always_comb begin
    tick_count_nxt     = tick_inc;
    rotation_count_nxt = rotation_count_r;
    seq_index_nxt      = seq_index_r;
    speed_valid        = 1'b0;
    speed              = '0;
    if (window_done) begin
      speed_valid        = 1'b1;
      speed              = (CMP_W'(rotation_count_r) > limit) ? bhcs_pkg::SPEED_OOR
                                                              : rot_shifted[7:0];
      tick_count_nxt     = '0;
      rotation_count_nxt = '0;
    end else if (in_order) begin
      seq_index_nxt = seq_index_r + 1'b1;
    end else if (seq_index_r >= bhcs_pkg::SEQ_LEN) begin
      seq_index_nxt = '0;
      if (rotation_count_r != '1) begin
        rotation_count_nxt = rotation_count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r     <= '0;
      rotation_count_r <= '0;
      seq_index_r      <= '0;
    end else if (fire) begin
      tick_count_r     <= tick_count_nxt;
      rotation_count_r <= rotation_count_nxt;
      seq_index_r      <= seq_index_nxt;
    end
  end

endmodule

@@ tb/bldc_hall_commutation_speed_tb.sv @@
`timescale 1ns / 100ps

module bldc_hall_commutation_speed_tb;

  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  // Cycles allowed after the last report before the block counts as idle.
  localparam int SETTLE_CYCLES = 4;
  // Hard stop for the run, far beyond the slowest legal run.
  localparam int RUN_LIMIT_NS = 3_000_000;

  typedef struct packed {
    logic [bhcs_pkg::DRIVE_W-1:0] bridge_drive;
    logic                         speed_valid;
    logic [bhcs_pkg::SPEED_W-1:0] speed;
  } speed_report_t;

  class commutation_scoreboard;
    logic [bhcs_pkg::WINDOW_W-1:0] window_ticks;
    logic [bhcs_pkg::SHIFT_W-1:0]  speed_shift;
    logic [bhcs_pkg::SEQ_W-1:0]    hall_pos;
    logic [COUNT_W-1:0]            rotations;
    logic [COUNT_W-1:0]            ticks;
    logic [bhcs_pkg::DRIVE_W-1:0]  drive;
    logic [bhcs_pkg::HALL_W-1:0]   rotation_order [6];
    speed_report_t                 pending_reports [$];
    int samples_noted;
    int reports_checked;
    int windows_closed;
    int clipped_reports;
    int mismatches;

    function new();
      rotation_order  = '{3'd3, 3'd1, 3'd5, 3'd4, 3'd6, 3'd2};
      window_ticks    = bhcs_pkg::WINDOW_TICKS_RST;
      speed_shift     = bhcs_pkg::SPEED_SHIFT_RST;
      hall_pos        = '0;
      rotations       = '0;
      ticks           = '0;
      drive           = '0;
      samples_noted   = 0;
      reports_checked = 0;
      windows_closed  = 0;
      clipped_reports = 0;
      mismatches      = 0;
    endfunction

    function void set_register(bhcs_pkg::cfg_idx_t idx,
                               logic [bhcs_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        bhcs_pkg::CFG_WINDOW_TICKS: window_ticks = value[bhcs_pkg::WINDOW_W-1:0];
        bhcs_pkg::CFG_SPEED_SHIFT:  speed_shift  = value[bhcs_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    endfunction

    // Advances the model by one Hall sample and returns the report it causes.
    function speed_report_t commutate(logic [bhcs_pkg::HALL_W-1:0] hall, logic pwm,
                                      logic tck);
      speed_report_t rep;
      logic [31:0]   clip_limit;
      case (hall)
        3'd2:    drive = bhcs_pkg::DRIVE_PAT_A | (6'(pwm) << 2);
        3'd3:    drive = bhcs_pkg::DRIVE_PAT_B | 6'(pwm);
        3'd1:    drive = bhcs_pkg::DRIVE_PAT_C | 6'(pwm);
        3'd5:    drive = bhcs_pkg::DRIVE_PAT_A | (6'(pwm) << 4);
        3'd4:    drive = bhcs_pkg::DRIVE_PAT_B | (6'(pwm) << 4);
        3'd6:    drive = bhcs_pkg::DRIVE_PAT_C | (6'(pwm) << 2);
        default: ;
      endcase
      rep.bridge_drive = drive;
      rep.speed_valid  = 1'b0;
      rep.speed        = '0;
      if (tck && ticks != COUNT_MAX)
        ticks++;
      if (ticks >= window_ticks) begin
        clip_limit = 32'(bhcs_pkg::SPEED_CLIP) << speed_shift;
        if (32'(rotations) > clip_limit) begin
          rep.speed = bhcs_pkg::SPEED_OOR;
          clipped_reports++;
        end else begin
          rep.speed = bhcs_pkg::SPEED_W'(rotations >> speed_shift);
        end
        rep.speed_valid = 1'b1;
        ticks     = '0;
        rotations = '0;
        windows_closed++;
      end else if (hall_pos < bhcs_pkg::SEQ_LEN && hall == rotation_order[hall_pos]) begin
        hall_pos++;
      end else if (hall_pos >= bhcs_pkg::SEQ_LEN) begin
        hall_pos = '0;
        if (rotations != COUNT_MAX)
          rotations++;
      end
      return rep;
    endfunction

    function void note_hall_sample(logic [bhcs_pkg::IN_TDATA_W-1:0] tdata);
      pending_reports.push_back(commutate(tdata[2:0], tdata[3], tdata[4]));
      samples_noted++;
    endfunction

    function void check_report(logic [bhcs_pkg::OUT_TDATA_W-1:0] tdata, logic tuser);
      speed_report_t want;
      if (pending_reports.size() == 0) begin
        $error("report 0x%h arrived with no sample outstanding", tdata);
        mismatches++;
        return;
      end
      want = pending_reports.pop_front();
      reports_checked++;
      if (tdata[5:0] !== want.bridge_drive) begin
        $error("bridge_drive: expected 0x%h, got 0x%h", want.bridge_drive, tdata[5:0]);
        mismatches++;
      end
      if (tuser !== want.speed_valid) begin
        $error("speed_valid: expected %b, got %b", want.speed_valid, tuser);
        mismatches++;
      end
      if (tdata[13:6] !== want.speed) begin
        $error("speed: expected %0d, got %0d", want.speed, tdata[13:6]);
        mismatches++;
      end
      if (tdata[15:14] !== 2'b00) begin
        $error("pad: expected 0, got %b", tdata[15:14]);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // [2:0] hall_code, [3] pwm_level, [4] tick, [7:5] zero
  logic [bhcs_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // [5:0] bridge_drive, [13:6] speed, [15:14] zero
  logic [bhcs_pkg::OUT_TDATA_W-1:0] out_tdata;
  // [0] speed_valid
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [bhcs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  commutation_scoreboard sb = new();

  // Traffic shaping knobs, set by the main sequence. A steady side never
  // idles; a hold request makes the receiver drop tready for that many cycles.
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int rx_hold_request = 0;
  int settings_used = 0;

  bldc_hall_commutation_speed #(
    .COUNT_WIDTH(COUNT_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both streams are observed in one process at the rising edge, so an
  // accepted sample is always queued before any report is checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_hall_sample(in_tdata);
      if (out_tvalid && out_tready)
        sb.check_report(out_tdata, out_tuser);
    end
  end

  // Gap lengths: mostly none, often a few cycles, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55)
      return 0;
    else if (roll < 88)
      return $urandom_range(1, 3);
    else if (roll < 97)
      return $urandom_range(4, 12);
    else
      return $urandom_range(20, 60);
  endfunction

  // Receiver: random tready, with an occasional long hold requested by the
  // main sequence so that the block backs up into its input.
  initial begin
    @(negedge clk);
    forever begin
      if (rx_hold_request > 0) begin
        out_tready = 1'b0;
        repeat (rx_hold_request) @(negedge clk);
        rx_hold_request = 0;
      end else if (rx_steady || $urandom_range(0, 2) != 0) begin
        out_tready = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        out_tready = 1'b0;
        repeat (pick_gap() + 1) @(negedge clk);
      end
    end
  end

  // All driver tasks start and end just after a falling edge.
  task automatic send_sample(input logic [bhcs_pkg::HALL_W-1:0] hall, input logic pwm,
                             input logic tck);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      in_tdata  = bhcs_pkg::IN_TDATA_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {3'b000, tck, pwm, hall};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Mostly follows the Hall order from wherever the tracker stands, so that
  // rotations really get counted; the rest is arbitrary codes.
  task automatic send_random_sample(input int tick_odds);
    logic [bhcs_pkg::HALL_W-1:0] hall;
    logic pwm;
    logic tck;
    pwm = 1'($urandom);
    tck = (tick_odds > 0) && ($urandom_range(1, tick_odds) == 1);
    if (sb.hall_pos < bhcs_pkg::SEQ_LEN && $urandom_range(0, 99) < 85)
      hall = sb.rotation_order[sb.hall_pos];
    else
      hall = bhcs_pkg::HALL_W'($urandom);
    send_sample(hall, pwm, tck);
  endtask

  // The sender pauses here until every queued report has come back.
  task automatic wait_for_reports();
    in_tvalid = 1'b0;
    while (sb.pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input bhcs_pkg::cfg_idx_t idx,
                                input logic [bhcs_pkg::CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_register(idx, value);
  endtask

  initial begin
    logic [bhcs_pkg::WINDOW_W-1:0] window;
    logic [bhcs_pkg::SHIFT_W-1:0]  shift;
    int tick_odds;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part with the reset configuration. Invalid codes right after
    // reset must hold the all-zero drive pattern.
    send_sample(3'd0, 1'b0, 1'b0);
    send_sample(3'd7, 1'b1, 1'b1);
    // One full rotation with the PWM bit high, then one with it low; the
    // invalid code after each one wraps the tracker and holds the last pattern.
    for (int k = 0; k < 6; k++)
      send_sample(sb.rotation_order[k], 1'b1, k[0]);
    send_sample(3'd0, 1'b1, 1'b0);
    for (int k = 0; k < 6; k++)
      send_sample(sb.rotation_order[k], 1'b0, !k[0]);
    send_sample(3'd7, 1'b0, 1'b1);

    // Smallest nonzero window and no shift: the next tick closes the window
    // and reports the two rotations seen so far.
    wait_for_reports();
    write_register(bhcs_pkg::CFG_WINDOW_TICKS, 16'd1);
    write_register(bhcs_pkg::CFG_SPEED_SHIFT, 16'd0);
    send_sample(3'd3, 1'b0, 1'b1);
    send_sample(3'd3, 1'b1, 1'b0);

    // A zero window closes on every sample, tick or not.
    wait_for_reports();
    write_register(bhcs_pkg::CFG_WINDOW_TICKS, 16'd0);
    send_sample(3'd1, 1'b1, 1'b0);
    send_sample(3'd5, 1'b0, 1'b0);
    send_sample(3'd4, 1'b1, 1'b1);
    settings_used += 3;

    // Random phases, each with its own register setting and traffic shape.
    for (int phase = 0; phase < 10; phase++) begin
      wait_for_reports();
      case ($urandom_range(0, 9))
        0:       window = '0;
        1:       window = 16'd1;
        2:       window = '1;
        3:       window = bhcs_pkg::WINDOW_W'($urandom);
        default: window = bhcs_pkg::WINDOW_W'($urandom_range(2, 40));
      endcase
      if (phase == 0)
        shift = '0;
      else if (phase == 1)
        shift = '1;
      else
        shift = bhcs_pkg::SHIFT_W'($urandom_range(0, 7));
      // Junk above the shift field must be ignored by the block.
      write_register(bhcs_pkg::CFG_SPEED_SHIFT, {13'($urandom), shift});
      write_register(bhcs_pkg::CFG_WINDOW_TICKS, window);
      settings_used++;
      tick_odds = $urandom_range(1, 10);
      tx_steady = (phase == 3) || ($urandom_range(0, 3) == 0);
      rx_steady = (phase == 3) || ($urandom_range(0, 3) == 0);
      if (phase == 5) begin
        // The receiver stalls for a long stretch while samples keep coming,
        // so the block fills up and drops in_tready.
        rx_hold_request = 60;
        tx_steady = 1'b1;
      end
      repeat (80) send_random_sample(tick_odds);
    end

    wait_for_reports();
    repeat (10) @(negedge clk);

    $display("Checked %0d reports for %0d Hall samples across %0d register settings.",
             sb.reports_checked, sb.samples_noted, settings_used);
    $display("Speed windows closed: %0d, of which %0d clipped to out of range.",
             sb.windows_closed, sb.clipped_reports);
    if (sb.pending_reports.size() != 0)
      $error("%0d expected reports never arrived", sb.pending_reports.size());
    if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $error("run did not complete in time");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
design/bhcs_pkg.sv
design/bhcs_commutate.sv
design/bhcs_speed_meter.sv
design/bldc_hall_commutation_speed.sv
tb/bldc_hall_commutation_speed_tb.sv
